// ===== rtl/bpfm_pkg.sv =====
package bpfm_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 5;
  localparam int MATCH_OFFSET_W  = 32;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int NEEDLE_BYTES    = 16;
  localparam int NEEDLE_IDX_W    = 4;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = CFG_INDEX_W'(2);

  typedef struct packed {
    logic shift;
    logic active;
  } cell_ctrl_t;

endpackage

// ===== rtl/bpfm_if.sv =====
interface bpfm_in_if;
  import bpfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface bpfm_out_if;
  import bpfm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [MATCH_OFFSET_W-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// ===== rtl/byte_pattern_first_match_unit.sv =====
// Streaming first-match byte search.
// haystack: one byte per transaction, end_of_text high on the final byte.
// result:   at most one transaction per haystack: found=1 with the start
//           offset of the first match, or found=0 (offset 0) on the final
//           byte when no match occurred. Bytes after a match give nothing.
// Configuration: cfg_we/cfg_index/cfg_data write the needle low bytes (0),
// high bytes (1) and length (2); other indexes are ignored. Write only while
// no haystack is in progress. A length of zero matches at offset 0 at once.
// Timing: a result is registered; it shows in the cycle after its byte is
// accepted. Throughput: one byte per cycle unless result stalls, set by the
// window cells that shift and compare in the same cycle as the byte arrives.
// Stall: a single output register holds an untaken result; haystack stays
// ready while that register is empty or being emptied in the same cycle.
// Reset: clears the needle, the byte count, the answered flag and the
// output valid flag. Window bytes need no reset, as they are only compared
// once the count shows them written. After the final byte the count and
// answered flag clear for the next haystack.
module byte_pattern_first_match_unit #(
  parameter int MAX_PATTERN = bpfm_pkg::MAX_PATTERN_DEF,
  parameter int OFFSET_BITS = bpfm_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpfm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bpfm_pkg::CFG_DATA_W-1:0]   cfg_data,
  bpfm_in_if.sink                           haystack,
  bpfm_out_if.source                        result
);
  import bpfm_pkg::*;

  logic [CFG_DATA_W-1:0]     pattern_low;
  logic [CFG_DATA_W-1:0]     pattern_high;
  logic [LEN_W-1:0]          pattern_length;
  logic [OFFSET_BITS-1:0]    bytes_seen;
  logic                      answered;
  logic                      out_valid;
  logic                      out_found;
  logic [MATCH_OFFSET_W-1:0] out_offset;

  logic [2*CFG_DATA_W-1:0]   needle_all;
  logic [LEN_W-1:0]          len_eff;
  logic [OFFSET_BITS-1:0]    count_next;
  logic [OFFSET_BITS-1:0]    offset_diff;
  logic                      in_fire;
  logic                      work;
  logic                      hit;
  logic                      emit;
  logic                      emit_found;
  logic [MATCH_OFFSET_W-1:0] emit_offset;

  logic [BYTE_W-1:0]         win      [MAX_PATTERN];
  logic [BYTE_W-1:0]         win_in   [MAX_PATTERN];
  logic [BYTE_W-1:0]         cell_ndl [MAX_PATTERN];
  cell_ctrl_t                cell_ctl [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]    cell_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign needle_all = {pattern_high, pattern_low};
  assign len_eff    = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                            : pattern_length;

  assign haystack.ready = !out_valid || result.ready;
  assign in_fire        = haystack.valid && haystack.ready;
  assign work           = in_fire && !answered;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
      logic [LEN_W-1:0] ndl_idx;

      if (gi == 0) begin : g_head
        assign win_in[gi] = haystack.data_byte;
      end else begin : g_link
        assign win_in[gi] = win[gi-1];
      end

      assign ndl_idx             = len_eff - LEN_W'(1) - LEN_W'(gi);
      assign cell_ndl[gi]        = needle_all[ndl_idx[NEEDLE_IDX_W-1:0]*BYTE_W +: BYTE_W];
      assign cell_ctl[gi].shift  = work;
      assign cell_ctl[gi].active = LEN_W'(gi) < len_eff;

      bpfm_cell u_cell (
        .clk         (clk),
        .ctrl        (cell_ctl[gi]),
        .byte_in     (win_in[gi]),
        .needle_byte (cell_ndl[gi]),
        .byte_out    (win[gi]),
        .eq          (cell_eq[gi])
      );
    end
  endgenerate

  assign count_next  = (bytes_seen == '1) ? bytes_seen : bytes_seen + OFFSET_BITS'(1);
  assign offset_diff = count_next - OFFSET_BITS'(len_eff);
  assign hit         = (count_next >= OFFSET_BITS'(len_eff)) && (&cell_eq);

  always_comb begin
    emit        = 1'b0;
    emit_found  = 1'b0;
    emit_offset = '0;
    if (work) begin
      if (len_eff == '0) begin
        emit       = 1'b1;
        emit_found = 1'b1;
      end else if (hit) begin
        emit        = 1'b1;
        emit_found  = 1'b1;
        emit_offset = MATCH_OFFSET_W'(offset_diff);
      end else if (haystack.end_of_text) begin
        emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      answered   <= 1'b0;
    end else if (in_fire) begin
      if (haystack.end_of_text) begin
        bytes_seen <= '0;
        answered   <= 1'b0;
      end else if (work) begin
        bytes_seen <= count_next;
        answered   <= emit_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_found  <= emit_found;
      out_offset <= emit_offset;
    end
  end

  assign result.valid        = out_valid;
  assign result.found        = out_found;
  assign result.match_offset = out_offset;

endmodule

// ===== rtl/bpfm_cell.sv =====
module bpfm_cell (
  input  logic                         clk,
  input  bpfm_pkg::cell_ctrl_t         ctrl,
  input  logic [bpfm_pkg::BYTE_W-1:0]  byte_in,
  input  logic [bpfm_pkg::BYTE_W-1:0]  needle_byte,
  output logic [bpfm_pkg::BYTE_W-1:0]  byte_out,
  output logic                         eq
);
  import bpfm_pkg::*;

  logic [BYTE_W-1:0] held;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  assign eq       = !ctrl.active || (byte_in == needle_byte);

endmodule

// ===== tb/sv/bpfm_match_checker.sv =====
`timescale 1ns / 1ps

module bpfm_match_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpfm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpfm_pkg::CFG_DATA_W-1:0]  cfg_data,
  bpfm_in_if                               haystack,
  bpfm_out_if                              result,
  output int                               outstanding,
  output int                               error_count
);
  import bpfm_pkg::*;

  typedef struct packed {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] match_offset;
  } search_answer_t;

  logic [CFG_DATA_W-1:0]     needle_lo;
  logic [CFG_DATA_W-1:0]     needle_hi;
  logic [LEN_W-1:0]          pat_len;
  logic [BYTE_W-1:0]         window [NEEDLE_BYTES];
  logic [MATCH_OFFSET_W-1:0] bytes_seen;
  logic                      answered;
  search_answer_t            pending_answers [$];
  int                        mismatches;

  function automatic void clear_search();
    for (int i = 0; i < NEEDLE_BYTES; i++) window[i] = '0;
    bytes_seen = '0;
    answered   = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [2*CFG_DATA_W-1:0] needle;
    int                      len;
    logic                    hit;
    logic                    emitted;
    needle  = {needle_hi, needle_lo};
    emitted = 1'b0;
    if (!answered) begin
      for (int i = NEEDLE_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (bytes_seen != '1) bytes_seen++;
      len = (pat_len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(pat_len);
      if (len == 0) begin
        pending_answers.push_back('{found: 1'b1, match_offset: '0});
        answered = 1'b1;
        emitted  = 1'b1;
      end else if (bytes_seen >= len) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (window[len-1-k] != needle[BYTE_W*k +: BYTE_W]) hit = 1'b0;
        end
        if (hit) begin
          pending_answers.push_back('{found: 1'b1,
                                      match_offset: MATCH_OFFSET_W'(bytes_seen - len)});
          answered = 1'b1;
          emitted  = 1'b1;
        end
      end
      if (!emitted && last) pending_answers.push_back('{found: 1'b0, match_offset: '0});
    end
    if (last) clear_search();
  endfunction

  always @(posedge clk) begin
    search_answer_t want;
    if (rst) begin
      needle_lo = '0;
      needle_hi = '0;
      pat_len   = '0;
      clear_search();
      pending_answers.delete();
      mismatches = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result expected none, actual found=%0b offset=%0d",
                   $time, result.found, result.match_offset);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          if (result.found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, result.found);
            mismatches++;
          end
          if (result.match_offset !== want.match_offset) begin
            $display("%0t: match_offset expected %0d actual %0d",
                     $time, want.match_offset, result.match_offset);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LOW:  needle_lo = cfg_data;
          REG_PATTERN_HIGH: needle_hi = cfg_data;
          REG_PATTERN_LEN:  pat_len   = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (haystack.valid && haystack.ready) scan_byte(haystack.data_byte, haystack.end_of_text);
    end
    outstanding <= pending_answers.size();
    error_count <= mismatches;
  end

endmodule

// ===== tb/sv/tb_byte_pattern_first_match_unit.sv =====
`timescale 1ns / 1ps

module tb_byte_pattern_first_match_unit;
  import bpfm_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);
  localparam int ITEM_TARGET = 1950;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_HAY     = 64;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     pending_results;
  int                     failures;
  int                     gap_pct;
  int                     stall_pct;
  int                     items_sent;
  int                     quiet_cycles;
  logic [BYTE_W-1:0]      needle [NEEDLE_BYTES];
  logic [BYTE_W-1:0]      hay_bytes [MAX_HAY];

  bpfm_in_if  hay_if ();
  bpfm_out_if res_if ();

  byte_pattern_first_match_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .haystack  (hay_if),
    .result    (res_if)
  );

  bpfm_match_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .haystack    (hay_if),
    .result      (res_if),
    .outstanding (pending_results),
    .error_count (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (hay_if.valid && hay_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      hay_if.valid <= 1'b0;
      @(posedge clk);
    end
    hay_if.valid       <= 1'b1;
    hay_if.data_byte   <= b;
    hay_if.end_of_text <= last;
    @(posedge clk);
    while (!hay_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // hold until every answer is back, then let the output register settle
  task automatic drain();
    hay_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_needle(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input logic [LEN_W-1:0] len, input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PATTERN_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_PATTERN_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_PATTERN_LEN;
    cfg_data  <= {$urandom, $urandom} & ~CFG_DATA_W'(5'h1f) | CFG_DATA_W'(len);
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(input bit narrow, input logic [BYTE_W-1:0] base);
    return narrow ? BYTE_W'(base + $urandom_range(1)) : BYTE_W'($urandom_range(255));
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [LEN_W-1:0]      len_code;
    logic [BYTE_W-1:0]     base;
    bit                    narrow;
    bit                    first;
    int                    eff_len;
    int                    hay_len;
    int                    at;

    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_PATTERN_LOW;
    cfg_data           <= '0;
    hay_if.valid       <= 1'b0;
    hay_if.data_byte   <= '0;
    hay_if.end_of_text <= 1'b0;
    gap_pct            <= 20;
    stall_pct          <= 67;
    items_sent         = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty needle: match on the first byte, later bytes only clear
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);
    drain();
    load_needle(CFG_DATA_W'(8'hff), '0, LEN_W'(1), 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b1);
    drain();
    // needle longer than the haystack
    load_needle(CFG_DATA_W'(24'hc3b2a1), '1, LEN_W'(3), 1'b1);
    push_byte(8'ha1, 1'b0);
    push_byte(8'hb2, 1'b1);
    drain();
    // oversized length clamps to a full window
    load_needle('1, '0, '1, 1'b1);
    push_byte(8'h00, 1'b0);
    for (int i = 0; i < 8; i++) push_byte(8'hff, 1'b0);
    for (int i = 0; i < 8; i++) push_byte(8'h00, i == 7);
    drain();

    first  = 1'b1;
    narrow = 1'b0;
    base   = '0;
    eff_len = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        gap_pct   <= 20;
        stall_pct <= 67;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        gap_pct   <= 67;
        stall_pct <= 20;
      end else begin
        gap_pct   <= 0;
        stall_pct <= 0;
      end
      if (first || $urandom_range(99) < 40) begin
        drain();
        first    = 1'b0;
        narrow   = ($urandom_range(3) != 0);
        base     = BYTE_W'($urandom_range(255));
        len_code = ($urandom_range(19) == 0) ? LEN_W'($urandom_range(31, 17))
                                             : LEN_W'($urandom_range(16));
        eff_len  = (len_code > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(len_code);
        for (int k = 0; k < NEEDLE_BYTES; k++) needle[k] = pick_byte(narrow, base);
        for (int k = 0; k < 8; k++) begin
          lo[BYTE_W*k +: BYTE_W] = needle[k];
          hi[BYTE_W*k +: BYTE_W] = needle[k+8];
        end
        load_needle(lo, hi, len_code, $urandom_range(4) == 0);
      end
      hay_len = ($urandom_range(9) == 0) ? $urandom_range(MAX_HAY, 17) : $urandom_range(16, 1);
      for (int i = 0; i < hay_len; i++) hay_bytes[i] = pick_byte(narrow, base);
      if ($urandom_range(1) && hay_len >= eff_len) begin
        at = $urandom_range(hay_len - eff_len);
        for (int k = 0; k < eff_len; k++) hay_bytes[at+k] = needle[k];
      end
      for (int i = 0; i < hay_len; i++) push_byte(hay_bytes[i], i == hay_len - 1);
    end

    hay_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
